// ===== hw/rtl/nsr_pkg.sv =====
package nsr_pkg;

  // fixed-point format
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;
  localparam int ROOT_W    = VAL_W - 1;
  localparam int SQ_W      = 2 * ROOT_W;
  localparam int DIVD_W    = VAL_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIVD_W);
  localparam int CNT_W     = 8;
  localparam int TOL_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};
  localparam logic [ROOT_W-1:0] ROOT_ONE = ROOT_W'(1);

  // reset values of the configuration registers
  localparam logic [TOL_W-1:0] TOL_RESET   = TOL_W'(1);
  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(32);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_TEST,
    S_DIV,
    S_UPD,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic div_start;
    logic div_step;
    logic update;
    logic mark_conv;
    logic mark_fail;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_zero;
    logic tol_ok;
    logic limit_hit;
    logic div_last;
  } sts_t;

endpackage

// ===== hw/rtl/nsr_ctrl.sv =====
module nsr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  nsr_pkg::sts_t  sts,
  output nsr_pkg::cmd_t  cmd
);

  nsr_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nsr_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      nsr_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = nsr_pkg::S_MUL;
        end
      end
      nsr_pkg::S_MUL: begin
        if (sts.is_zero) begin
          cmd.mark_conv = 1'b1;
          state_nxt     = nsr_pkg::S_DONE;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = nsr_pkg::S_TEST;
        end
      end
      nsr_pkg::S_TEST: begin
        if (sts.tol_ok) begin
          cmd.mark_conv = 1'b1;
          state_nxt     = nsr_pkg::S_DONE;
        end else if (sts.limit_hit) begin
          cmd.mark_fail = 1'b1;
          state_nxt     = nsr_pkg::S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = nsr_pkg::S_DIV;
        end
      end
      nsr_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = nsr_pkg::S_UPD;
        end
      end
      nsr_pkg::S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = nsr_pkg::S_MUL;
      end
      nsr_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = nsr_pkg::S_IDLE;
        end
      end
      default: state_nxt = nsr_pkg::S_IDLE;
    endcase
  end

  // output slot: filled on load, emptied when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_stall  = (state_r != nsr_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/nsr_datapath.sv =====
module nsr_datapath (
  input  logic                          clk,
  input  nsr_pkg::cmd_t                 cmd,
  output nsr_pkg::sts_t                 sts,
  input  logic [nsr_pkg::VAL_W-1:0]     in_radicand,
  input  logic [nsr_pkg::TOL_W-1:0]     tolerance,
  input  logic [nsr_pkg::CNT_W-1:0]     iteration_limit,
  output logic [nsr_pkg::ROOT_W-1:0]    out_root,
  output logic [nsr_pkg::CNT_W-1:0]     out_steps_taken,
  output logic                          out_converged
);

  localparam int VAL_W     = nsr_pkg::VAL_W;
  localparam int ROOT_W    = nsr_pkg::ROOT_W;
  localparam int SQ_W      = nsr_pkg::SQ_W;
  localparam int DIVD_W    = nsr_pkg::DIVD_W;
  localparam int DIV_CNT_W = nsr_pkg::DIV_CNT_W;
  localparam int CNT_W     = nsr_pkg::CNT_W;
  localparam int FRAC_BITS = nsr_pkg::FRAC_BITS;

  logic [VAL_W-1:0]     value_r, value_nxt;
  logic [ROOT_W-1:0]    est_r, est_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [SQ_W-1:0]      sq_r, sq_nxt;
  logic [ROOT_W-1:0]    rem_r, rem_nxt;
  logic [DIVD_W-1:0]    dvd_r, dvd_nxt;
  logic [DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic                 conv_r, conv_nxt;
  logic [ROOT_W-1:0]    root_r;
  logic [CNT_W-1:0]     steps_r;
  logic                 res_conv_r;

  logic [ROOT_W-1:0]    half_v;
  logic [SQ_W-1:0]      sq_shift;
  logic [SQ_W-1:0]      v_ext;
  logic [SQ_W-1:0]      diff;
  logic [ROOT_W:0]      trial;
  logic                 fits;
  logic [DIVD_W:0]      sum;
  logic [DIVD_W-1:0]    mean;

  // start estimate: half the value, at least one lsb unless the value is zero
  assign half_v = in_radicand[VAL_W-1:1];

  // tolerance test on the registered square
  assign sq_shift = sq_r >> FRAC_BITS;
  assign v_ext    = SQ_W'(value_r);
  assign diff     = (sq_shift >= v_ext) ? (sq_shift - v_ext) : (v_ext - sq_shift);

  // restoring division, one quotient bit a cycle
  assign trial = {rem_r, dvd_r[DIVD_W-1]};
  assign fits  = (trial >= {1'b0, est_r});

  // new estimate: mean of estimate and quotient, saturated, never zero
  assign sum  = {1'b0, dvd_r} + (DIVD_W + 1)'(est_r);
  assign mean = sum[DIVD_W:1];

  always_comb begin
    value_nxt = value_r;
    est_nxt   = est_r;
    cnt_nxt   = cnt_r;
    sq_nxt    = sq_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    dcnt_nxt  = dcnt_r;
    conv_nxt  = conv_r;
    if (cmd.load) begin
      value_nxt = in_radicand;
      cnt_nxt   = '0;
      if (half_v != '0) begin
        est_nxt = half_v;
      end else if (in_radicand != '0) begin
        est_nxt = nsr_pkg::ROOT_ONE;
      end else begin
        est_nxt = '0;
      end
    end
    if (cmd.mul) begin
      sq_nxt = SQ_W'(est_r) * SQ_W'(est_r);
    end
    if (cmd.div_start) begin
      rem_nxt  = '0;
      dvd_nxt  = {value_r, {FRAC_BITS{1'b0}}};
      dcnt_nxt = '0;
    end
    if (cmd.div_step) begin
      rem_nxt  = fits ? ROOT_W'(trial - {1'b0, est_r}) : ROOT_W'(trial);
      dvd_nxt  = {dvd_r[DIVD_W-2:0], fits};
      dcnt_nxt = dcnt_r + DIV_CNT_W'(1);
    end
    if (cmd.update) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (mean > DIVD_W'(nsr_pkg::ROOT_MAX)) begin
        est_nxt = nsr_pkg::ROOT_MAX;
      end else if (mean == '0) begin
        est_nxt = nsr_pkg::ROOT_ONE;
      end else begin
        est_nxt = mean[ROOT_W-1:0];
      end
    end
    if (cmd.mark_conv) begin
      conv_nxt = 1'b1;
    end else if (cmd.mark_fail) begin
      conv_nxt = 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    est_r   <= est_nxt;
    cnt_r   <= cnt_nxt;
    sq_r    <= sq_nxt;
    rem_r   <= rem_nxt;
    dvd_r   <= dvd_nxt;
    dcnt_r  <= dcnt_nxt;
    conv_r  <= conv_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      root_r     <= est_r;
      steps_r    <= cnt_r;
      res_conv_r <= conv_r;
    end
  end

  assign sts.is_zero   = (value_r == '0);
  assign sts.tol_ok    = (diff <= SQ_W'(tolerance));
  assign sts.limit_hit = (cnt_r >= iteration_limit);
  assign sts.div_last  = (dcnt_r == DIV_CNT_W'(DIVD_W - 1));

  assign out_root        = root_r;
  assign out_steps_taken = steps_r;
  assign out_converged   = res_conv_r;

endmodule

// ===== hw/rtl/newton_square_root_top.sv =====
// Newton square root, unsigned Q16.16 in, unsigned Q15.16 out, one item at a time.
// A zero radicand goes straight to the result; otherwise each of the steps_taken
// steps is a bit-serial divider pass plus square, test and update states. A new
// item is taken once the result has moved to the output register. Reset clears
// the controller and the output valid, and sets tolerance to 1 and iteration_limit
// to 32.
module newton_square_root_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [nsr_pkg::VAL_W-1:0]         in_radicand,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [nsr_pkg::ROOT_W-1:0]        out_root,
  output logic [nsr_pkg::CNT_W-1:0]         out_steps_taken,
  output logic                              out_converged,
  input  logic                              cfg_we,
  input  logic [nsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nsr_pkg::CFG_W-1:0]         cfg_wdata
);

  logic [nsr_pkg::TOL_W-1:0] tol_r, tol_nxt;
  logic [nsr_pkg::CNT_W-1:0] limit_r, limit_nxt;
  nsr_pkg::cmd_t             cmd;
  nsr_pkg::sts_t             sts;

  // configuration register decode
  always_comb begin
    tol_nxt   = tol_r;
    limit_nxt = limit_r;
    if (cfg_we) begin
      unique case (cfg_index)
        nsr_pkg::REG_TOLERANCE:  tol_nxt   = cfg_wdata[nsr_pkg::TOL_W-1:0];
        nsr_pkg::REG_ITER_LIMIT: limit_nxt = cfg_wdata[nsr_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= nsr_pkg::TOL_RESET;
      limit_r <= nsr_pkg::LIMIT_RESET;
    end else begin
      tol_r   <= tol_nxt;
      limit_r <= limit_nxt;
    end
  end

  nsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  nsr_datapath u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .sts             (sts),
    .in_radicand     (in_radicand),
    .tolerance       (tol_r),
    .iteration_limit (limit_r),
    .out_root        (out_root),
    .out_steps_taken (out_steps_taken),
    .out_converged   (out_converged)
  );

endmodule
